// ===== rtl/edd_pkg.sv =====
// Shared constants, types and the per-channel quantiser for the RGBA4444 ditherer.
// Depends on nothing; the top level imports it.
`default_nettype none

package edd_pkg;

    // Field and register widths.
    localparam int CH_W           = 8;
    localparam int NUM_CH         = 4;
    localparam int NIB_W          = 4;
    localparam int ERR_W          = 12;
    localparam int DIFF_W         = 8;
    localparam int LINE_WIDTH_W   = 11;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int IN_DATA_W      = CH_W * NUM_CH;
    localparam int OUT_DATA_W     = NIB_W * NUM_CH;
    localparam int ENTRY_W        = ERR_W * NUM_CH;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = LINE_WIDTH_W'(1024);

    typedef logic signed [ERR_W-1:0]  t_err;
    typedef logic signed [DIFF_W-1:0] t_diff;

    typedef struct packed {
        logic [NIB_W-1:0] nib;
        t_diff            diff;
    } t_quant;

    // Corrects one channel by the incoming error, clamps it, quantises it to
    // four bits and returns the quantisation error scaled by 8.
    function automatic t_quant quantise(input logic [CH_W-1:0] pin, input t_err above,
                                        input t_err carry);
        logic signed [ERR_W:0] acc;
        logic signed [5:0]     adj;
        logic signed [9:0]     vs;
        logic [7:0]            v;
        logic [8:0]            vr;
        logic [4:0]            q;
        logic signed [9:0]     rem;
        t_quant                res;
        acc = (ERR_W+1)'(above) + (ERR_W+1)'(carry);
        // Arithmetic shift gives the floor of the division by 128.
        adj = 6'(acc >>> 7);
        vs  = $signed({2'b00, pin}) + 10'(adj);
        if (vs < 0) begin
            v = 8'd0;
        end else if (vs > 10'sd255) begin
            v = 8'd255;
        end else begin
            v = vs[7:0];
        end
        vr  = {1'b0, v} + 9'd8;
        q   = vr[8:4];
        // The error uses the unsaturated level: 8 * (v - 16q).
        rem = $signed({2'b00, v}) - $signed({1'b0, q, 4'b0000});
        res.diff = {rem[4:0], 3'b000};
        res.nib  = (q > 5'd15) ? 4'hF : q[3:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/error_diffusion_dither_rgba4444.sv =====
// Floyd-Steinberg ditherer from RGBA8888 to RGBA4444, one pixel per clock while the output is not stalled.
// Depends on edd_pkg; holds the error line store as an internal memory.
//
//  Channel | Signals                       | Beat contents
//  --------+-------------------------------+------------------------------------
//  input   | s_axis_tvalid/tready/tdata    | tdata: red, green, blue, alpha
//          | s_axis_tuser                  | tuser: start of frame
//  output  | m_axis_tvalid/tready/tdata    | tdata: RGBA4444 word
//          | m_axis_tlast                  | tlast: last pixel of the row
//  config  | i_cfg_we, i_cfg_wdata         | pixels per row
//
// A beat passes from input to output through the input register, where
// the line store is read, and the result register. One pixel per cycle is
// sustained while the output is not stalled; the single-pass error update in the first stage sets that rate.
// Reset clears the column counter, carries and handshakes; the line store
// is not cleared. A stalled output holds the pixel in the input register.
`default_nettype none

module error_diffusion_dither_rgba4444 #(
    parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // Configuration: pixels per row.
    input  wire                                    i_cfg_we,
    input  wire  [edd_pkg::LINE_WIDTH_W-1:0]       i_cfg_wdata,
    // Pixel input.
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    input  wire  [edd_pkg::IN_DATA_W-1:0]          s_axis_tdata,
    // [0] start_of_frame
    input  wire                                    s_axis_tuser,
    // Pixel output.
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    // [15:0] pixel_4444
    output logic [edd_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tlast
);
    import edd_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (LINE_WIDTH_W > AW + 1) ? LINE_WIDTH_W : AW + 1;

    // Configuration register.
    logic [LINE_WIDTH_W-1:0] r_line_width;

    // Front end: column tracking.
    logic [AW-1:0] r_column;
    logic          r_first_row;

    // Input register stage.
    logic                 r_in_valid;
    logic [IN_DATA_W-1:0] r_px;
    logic                 r_sof;
    logic                 r_first;
    logic                 r_last;
    logic [AW-1:0]        r_col;

    // Line store and its read port with bypass.
    logic [ENTRY_W-1:0] r_line_mem [MAX_WIDTH];
    logic [ENTRY_W-1:0] r_rd_raw;
    logic [ENTRY_W-1:0] r_byp_data;
    logic               r_byp_hit;

    // Carries between neighbouring pixels of a row.
    t_err  r_right_carry [NUM_CH];
    t_err  r_below_left  [NUM_CH];
    t_diff r_below       [NUM_CH];

    // Second write of a row end, issued the cycle after.
    logic               r_pend_valid;
    logic [AW-1:0]      r_pend_addr;
    logic [ENTRY_W-1:0] r_pend_data;

    // Result register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    logic                  accept;
    logic                  advance;
    logic                  sof_in;
    logic [AW-1:0]         f_col;
    logic                  f_last;
    logic [CMPW-1:0]       lw_ext;
    logic [CMPW-1:0]       w_eff;
    logic [CMPW-1:0]       col_p1;

    logic [ENTRY_W-1:0]    above_word;
    logic [ENTRY_W-1:0]    left_word;
    logic [ENTRY_W-1:0]    here_word;
    logic [OUT_DATA_W-1:0] n_word;
    t_err                  n_right_carry [NUM_CH];
    t_err                  n_below_left  [NUM_CH];
    t_diff                 n_below       [NUM_CH];

    logic                  proc_we;
    logic [AW-1:0]         proc_addr;
    logic [ENTRY_W-1:0]    proc_data;
    logic                  n_pend_valid;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign advance = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign sof_in  = s_axis_tuser;

    // Effective row width and end-of-row decision for the arriving pixel.
    always_comb begin
        lw_ext = CMPW'(r_line_width);
        if (lw_ext == '0) begin
            w_eff = CMPW'(1);
        end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = lw_ext;
        end
        f_col  = sof_in ? '0 : r_column;
        col_p1 = CMPW'(f_col) + CMPW'(1);
        f_last = (col_p1 >= w_eff);
    end

    // Configuration and column tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_column     <= '0;
            r_first_row  <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_line_width <= i_cfg_wdata;
            end
            if (accept) begin
                r_column    <= f_last ? '0 : AW'(col_p1);
                r_first_row <= f_last ? 1'b0 : (sof_in || r_first_row);
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px    <= s_axis_tdata;
            r_sof   <= sof_in;
            r_first <= sof_in || r_first_row;
            r_last  <= f_last;
            r_col   <= f_col;
        end
    end

    // Line store: one write and one registered read a cycle. A write to the
    // address being read in the same cycle is caught by the bypass.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            r_rd_raw   <= r_line_mem[f_col];
            r_byp_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (accept) begin
            r_byp_hit <= wr_en && (wr_addr == f_col);
        end
    end

    assign above_word = r_first ? '0 : (r_byp_hit ? r_byp_data : r_rd_raw);

    // Per-channel quantisation and error spreading.
    always_comb begin
        t_quant qr;
        t_err   rc;
        t_err   bl;
        t_err   bp;
        t_err   d;
        n_word    = '0;
        left_word = '0;
        here_word = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            rc = r_sof ? '0 : r_right_carry[c];
            bl = r_sof ? '0 : r_below_left[c];
            bp = r_sof ? '0 : ERR_W'(r_below[c]);
            qr = quantise(r_px[c*CH_W +: CH_W], above_word[c*ERR_W +: ERR_W], rc);
            d  = ERR_W'(qr.diff);
            n_word[(NUM_CH-1-c)*NIB_W +: NIB_W] = qr.nib;
            left_word[c*ERR_W +: ERR_W] = bl + ERR_W'(d * 3);
            here_word[c*ERR_W +: ERR_W] = bp + ERR_W'(d * 5);
            n_right_carry[c] = ERR_W'(d * 7);
            n_below_left[c]  = bp + ERR_W'(d * 5);
            n_below[c]       = qr.diff;
        end
    end

    // Write selection: the left neighbour's entry when there is one, else
    // this entry at a row end; a row end with a left neighbour defers its
    // own entry to the next cycle.
    always_comb begin
        proc_we      = 1'b0;
        proc_addr    = r_col;
        proc_data    = here_word;
        n_pend_valid = 1'b0;
        if (advance) begin
            if (r_col != '0) begin
                proc_we      = 1'b1;
                proc_addr    = r_col - AW'(1);
                proc_data    = left_word;
                n_pend_valid = r_last;
            end else if (r_last) begin
                proc_we = 1'b1;
            end
        end
        if (r_pend_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_pend_addr;
            wr_data = r_pend_data;
        end else begin
            wr_en   = proc_we;
            wr_addr = proc_addr;
            wr_data = proc_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_pend_valid) begin
            r_pend_addr <= r_col;
            r_pend_data <= here_word;
        end
    end

    // Carries: cleared at a row end, else taken from this pixel; a frame start masks the old ones.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_right_carry[c] <= '0;
                r_below_left[c]  <= '0;
                r_below[c]       <= '0;
            end
        end else if (advance) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (r_last) begin
                    r_right_carry[c] <= '0;
                    r_below_left[c]  <= '0;
                    r_below[c]       <= '0;
                end else begin
                    r_right_carry[c] <= n_right_carry[c];
                    r_below_left[c]  <= n_below_left[c];
                    r_below[c]       <= n_below[c];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_word;
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // The deferred row-end write never meets a write from the current pixel.
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend_valid && proc_we))
        else $error("line store write collision");

    // A deferred write only follows a row end that has just left the stage.
    a_pend_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> $past(advance && r_last))
        else $error("deferred write without a row end");

    // An accepted row end restarts the column count.
    a_column_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && f_last) |=> (r_column == '0))
        else $error("column not restarted after row end");

    // A pixel that is not a row end leaves no deferred write behind.
    a_no_pend_midrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_last) |=> !r_pend_valid)
        else $error("deferred write inside a row");
`endif

endmodule

`default_nettype wire
